/* sv/binary_outline_point_detector_top_macros.svh */
// Assertion helpers for the RTL modules, included by the controller module.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BINARY_OUTLINE_POINT_DETECTOR_TOP_MACROS_SVH
`define BINARY_OUTLINE_POINT_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication
`define BOPD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BOPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/bopd_pkg.sv */
package bopd_pkg;

	// Image limits and field widths
	localparam int MAX_WIDTH  = 32;
	localparam int MAX_HEIGHT = 256;
	localparam int PIXEL_BITS = 32;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = COL_W + 1;
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int HGT_W      = ROW_W + 1;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BG_COLOUR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = CFG_IDX_W'(2);

	// Controller to datapath
	typedef struct packed {
		logic take;   // pixel transaction accepted this cycle
		logic scan;   // flush scan visits one column of the last row
		logic term;   // load terminator and restart the image
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_pixel; // pixel at the current position closes the image
		logic scan_done;  // scan column is the last column
		logic out_free;   // result register can take a new result
	} sts_t;

endpackage

/* sv/bopd_dpath.sv */
module bopd_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bopd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bopd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [bopd_pkg::PIXEL_BITS-1:0]     pixel_value,
	input  bopd_pkg::cmd_t                      cmd,
	output bopd_pkg::sts_t                      sts,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [bopd_pkg::COL_W-1:0]          point_col,
	output logic [bopd_pkg::ROW_W-1:0]          point_row,
	output logic                                point_valid,
	output logic                                frame_last
);
	import bopd_pkg::*;

	// Configuration
	logic [PIXEL_BITS-1:0] bg_q;
	logic [WID_W-1:0]      width_q;
	logic [HGT_W-1:0]      height_q;

	// Line buffers of foreground bits and position counters
	logic [MAX_WIDTH-1:0]  cur_q, prev_q, above_q;
	logic [COL_W-1:0]      col_q, x_q;
	logic [ROW_W-1:0]      row_q;

	// Result register
	logic                  res_valid_q;
	logic [COL_W-1:0]      res_col_q;
	logic [ROW_W-1:0]      res_row_q;
	logic                  res_pv_q, res_last_q;

	logic [COL_W-1:0]      width_m1, col_c;
	logic                  fg;
	logic [MAX_WIDTH-1:0]  cur_eff, edge_mask;
	logic [HGT_W-1:0]      row_inc;
	logic                  take_emit, load, out_free;
	logic [WID_W-1:0]      wr_width;
	logic [HGT_W-1:0]      wr_height;

	// Current column (clamped), foreground test and merged current row
	always_comb begin
		width_m1 = COL_W'(width_q - 1'b1);
		col_c    = ({1'b0, col_q} >= width_q) ? width_m1 : col_q;
		fg       = pixel_value != bg_q;
		cur_eff  = cur_q | (fg ? ({{(MAX_WIDTH-1){1'b0}}, 1'b1} << col_c) : '0);
	end

	// Outline test of the previous row, every column in parallel
	always_comb begin
		logic in_w, left, right;
		for (int x = 0; x < MAX_WIDTH; x++) begin
			in_w  = WID_W'(x) < width_q;
			left  = (x > 0) ? prev_q[(x > 0) ? x - 1 : 0] : 1'b0;
			right = ((x + 1 < MAX_WIDTH) && (WID_W'(x + 1) < width_q)) ?
				prev_q[(x + 1 < MAX_WIDTH) ? x + 1 : x] : 1'b0;
			edge_mask[x] = in_w && prev_q[x] &&
				!(above_q[x] && cur_eff[x] && left && right);
		end
	end

	// Status toward the controller
	always_comb begin
		row_inc        = {1'b0, row_q} + 1'b1;
		take_emit      = (row_q != '0) && edge_mask[col_c];
		out_free       = !res_valid_q || !res_stall;
		sts.last_pixel = (col_c == width_m1) && (row_inc >= height_q);
		sts.scan_done  = x_q == width_m1;
		sts.out_free   = out_free;
		load = (cmd.take && take_emit) || (cmd.scan && cur_q[x_q]) || cmd.term;
	end

	// Clamp written sizes into range
	always_comb begin
		wr_width = cfg_data[WID_W-1:0];
		if (wr_width == '0)
			wr_width = WID_W'(1);
		else if (wr_width > WID_W'(MAX_WIDTH))
			wr_width = WID_W'(MAX_WIDTH);
		wr_height = cfg_data[HGT_W-1:0];
		if (wr_height == '0)
			wr_height = HGT_W'(1);
		else if (wr_height > HGT_W'(MAX_HEIGHT))
			wr_height = HGT_W'(MAX_HEIGHT);
	end

	// Configuration, line buffers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q     <= '0;
			width_q  <= WID_W'(MAX_WIDTH < 32 ? MAX_WIDTH : 32);
			height_q <= HGT_W'(MAX_HEIGHT < 32 ? MAX_HEIGHT : 32);
			cur_q    <= '0;
			prev_q   <= '0;
			above_q  <= '0;
			col_q    <= '0;
			row_q    <= '0;
			x_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				REG_BG_COLOUR: bg_q <= cfg_data[PIXEL_BITS-1:0];
				REG_WIDTH, REG_HEIGHT: begin
					if (cfg_index == REG_WIDTH)
						width_q <= wr_width;
					else
						height_q <= wr_height;
					cur_q   <= '0;
					prev_q  <= '0;
					above_q <= '0;
					col_q   <= '0;
					row_q   <= '0;
				end
				default: ;
			endcase
		end else if (cmd.term) begin
			// image done: restart
			cur_q   <= '0;
			prev_q  <= '0;
			above_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cmd.take) begin
			x_q <= '0;
			if (sts.last_pixel) begin
				cur_q <= cur_eff;
			end else if (col_c == width_m1) begin
				above_q <= prev_q;
				prev_q  <= cur_eff;
				cur_q   <= '0;
				col_q   <= '0;
				row_q   <= row_q + 1'b1;
			end else begin
				cur_q <= cur_eff;
				col_q <= col_c + 1'b1;
			end
		end else if (cmd.scan) begin
			x_q <= x_q + 1'b1;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_free)
			res_valid_q <= load;
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (out_free && load) begin
			if (cmd.term) begin
				res_col_q  <= '0;
				res_row_q  <= '0;
				res_pv_q   <= 1'b0;
				res_last_q <= 1'b1;
			end else if (cmd.scan) begin
				res_col_q  <= x_q;
				res_row_q  <= row_q;
				res_pv_q   <= 1'b1;
				res_last_q <= 1'b0;
			end else begin
				res_col_q  <= col_c;
				res_row_q  <= row_q - 1'b1;
				res_pv_q   <= 1'b1;
				res_last_q <= 1'b0;
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign point_col   = res_col_q;
	assign point_row   = res_row_q;
	assign point_valid = res_pv_q;
	assign frame_last  = res_last_q;

endmodule

/* sv/bopd_ctrl.sv */
module bopd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pix_valid,
	output logic           pix_stall,
	input  bopd_pkg::sts_t sts,
	output bopd_pkg::cmd_t cmd
);
	import bopd_pkg::*;

	`include "binary_outline_point_detector_top_macros.svh"

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_FLUSH = 2'd1;
	localparam logic [1:0] ST_TERM  = 2'd2;

	logic [1:0] state_q, state_d;

	// Commands and next state
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		pix_stall = 1'b1;
		unique case (state_q)
			ST_RUN: begin
				pix_stall = !sts.out_free;
				if (pix_valid && sts.out_free) begin
					cmd.take = 1'b1;
					if (sts.last_pixel)
						state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				// one column of the last row per free slot
				if (sts.out_free) begin
					cmd.scan = 1'b1;
					if (sts.scan_done)
						state_d = ST_TERM;
				end
			end
			ST_TERM: begin
				if (sts.out_free) begin
					cmd.term = 1'b1;
					state_d  = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_RUN;
		else
			state_q <= state_d;
	end

	`BOPD_ASSERT_NEXT(a_last_starts_flush, cmd.take && sts.last_pixel,
		state_q == ST_FLUSH, "final pixel did not start the flush")
	`BOPD_ASSERT_NEXT(a_flush_holds, state_q == ST_FLUSH && !sts.out_free,
		state_q == ST_FLUSH, "flush advanced while result register was full")
	`BOPD_ASSERT_NEXT(a_term_returns, cmd.term,
		state_q == ST_RUN && !cmd.scan, "terminator did not return to pixel intake")

endmodule

/* sv/binary_outline_point_detector_top.sv */
// Binary outline point detector. Pixels arrive in raster order; a pixel whose
// value differs from the background register is foreground, and each
// foreground pixel with a background or out-of-image 4-neighbour is reported
// as (column, row). Points of row r-1 come out while row r streams in, so
// intake runs at one pixel per cycle as long as results are taken. At the
// final pixel of the image the controller scans the last row one column per
// cycle while results are taken and then sends a terminator with frame_last
// set; pix_stall stays high through that tail. Writing the width or height
// restarts the image; configure only while the block is idle.
// No clearing pass is needed after reset.
module binary_outline_point_detector_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bopd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bopd_pkg::CFG_DATA_W-1:0]  cfg_data,
	// pixel stream
	input  logic                             pix_valid,
	output logic                             pix_stall,
	input  logic [bopd_pkg::PIXEL_BITS-1:0]  pixel_value,
	// outline points
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic [bopd_pkg::COL_W-1:0]       point_col,
	output logic [bopd_pkg::ROW_W-1:0]       point_row,
	output logic                             point_valid,
	output logic                             frame_last
);
	import bopd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	bopd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bopd_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_value (pixel_value),
		.cmd         (cmd),
		.sts         (sts),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.point_col   (point_col),
		.point_row   (point_row),
		.point_valid (point_valid),
		.frame_last  (frame_last)
	);

endmodule
